### rtl/ukdp_pkg.sv
// Package for the unbounded knapsack block: sizes, widths, state and
// controller/datapath interface types.
// Used by every module in rtl/ except ukdp_ram; depends on nothing.
package ukdp_pkg;

    // Table geometry
    localparam int CAPACITY   = 16;
    localparam int VALUE_BITS = 24;
    localparam int DEPTH      = CAPACITY + 1;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(CAPACITY + 2);

    // Port field widths
    localparam int SIZE_W     = 8;
    localparam int ITEM_VAL_W = 16;
    localparam int CAP_W      = 5;
    localparam int OUT_VAL_W  = 24;

    typedef logic [ADDR_W-1:0]     t_addr;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [VALUE_BITS-1:0] t_value;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_DRAIN,
        S_EMIT
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic sweep_rd;
        logic emit;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic skip;
        logic sweep_last;
        logic emit_done;
    } t_stat;

endpackage

### rtl/ukdp_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
// Read returns the old contents on a same-cycle write. No dependencies.
module ukdp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 17
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read ports
    always_ff @(posedge i_clk) begin
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

### rtl/ukdp_ctrl.sv
// Controller state machine for the knapsack block: accept, sweep, drain, emit.
// Depends on ukdp_pkg.
module ukdp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_item_valid,
    output logic            o_item_ready,
    input  ukdp_pkg::t_stat i_stat,
    output ukdp_pkg::t_cmd  o_cmd
);

    ukdp_pkg::t_state r_state;
    ukdp_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ukdp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_item_ready = 1'b0;
        case (r_state)
            ukdp_pkg::S_IDLE: begin
                o_item_ready = 1'b1;
                o_cmd.accept = i_item_valid;
                if (i_item_valid) begin
                    n_state = ukdp_pkg::S_SWEEP;
                end
            end
            ukdp_pkg::S_SWEEP: begin
                o_cmd.sweep_rd = !i_stat.skip;
                if (i_stat.skip || i_stat.sweep_last) begin
                    n_state = ukdp_pkg::S_DRAIN;
                end
            end
            ukdp_pkg::S_DRAIN: begin
                // let the last table write land before the row is read
                n_state = ukdp_pkg::S_EMIT;
            end
            ukdp_pkg::S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_stat.emit_done) begin
                    n_state = ukdp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ukdp_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### rtl/ukdp_datapath.sv
// Datapath for the knapsack block: table RAM, valid bits, sweep pipeline with
// forwarding, row read-out and the result register.
// Depends on ukdp_pkg and ukdp_ram.
module ukdp_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ukdp_pkg::t_cmd                      i_cmd,
    output ukdp_pkg::t_stat                     o_stat,
    input  logic                                i_cfg_valid,
    input  logic [ukdp_pkg::CAP_W-1:0]          i_cfg_capacity_in_use,
    input  logic [ukdp_pkg::SIZE_W-1:0]         i_item_size,
    input  logic [ukdp_pkg::ITEM_VAL_W-1:0]     i_item_value,
    input  logic                                i_start_new_set,
    output logic                                o_res_valid,
    input  logic                                i_res_ready,
    output logic [ukdp_pkg::CAP_W-1:0]          o_capacity,
    output logic [ukdp_pkg::OUT_VAL_W-1:0]      o_best_value,
    output logic                                o_last_of_row
);

    // Configuration and item registers
    logic [ukdp_pkg::CAP_W-1:0]      r_cap;
    logic [ukdp_pkg::SIZE_W-1:0]     r_size;
    logic [ukdp_pkg::ITEM_VAL_W-1:0] r_value;
    ukdp_pkg::t_addr                 r_use;
    ukdp_pkg::t_addr                 n_use;

    // Sweep pipeline
    ukdp_pkg::t_addr                 r_c;
    logic [ukdp_pkg::DEPTH-1:0]      r_valid;
    logic                            r_va;
    logic                            r_vb;
    logic                            r_upd_v;
    ukdp_pkg::t_addr                 r_upd_c;
    ukdp_pkg::t_addr                 r_upd_b;
    logic                            r_fwd_v;
    ukdp_pkg::t_addr                 r_fwd_addr;
    ukdp_pkg::t_value                r_fwd_data;

    // Row read-out
    ukdp_pkg::t_cnt                  r_e;
    logic                            r_pend;
    ukdp_pkg::t_addr                 r_pend_c;

    // Result register
    logic                            r_res_valid;
    logic [ukdp_pkg::CAP_W-1:0]      r_res_cap;
    logic [ukdp_pkg::OUT_VAL_W-1:0]  r_res_val;
    logic                            r_res_last;

    ukdp_pkg::t_addr                 rd_a_addr;
    ukdp_pkg::t_addr                 rd_b_addr;
    ukdp_pkg::t_addr                 base_addr;
    ukdp_pkg::t_value                rd_a;
    ukdp_pkg::t_value                rd_b;
    ukdp_pkg::t_value                base;
    ukdp_pkg::t_value                old_v;
    ukdp_pkg::t_value                cand;
    ukdp_pkg::t_value                new_v;
    ukdp_pkg::t_value                emit_v;
    logic [ukdp_pkg::VALUE_BITS:0]   sum;
    logic                            emit_more;
    logic                            emit_load;
    logic                            emit_issue;

    // Clamp the capacity register into 1..CAPACITY
    always_comb begin
        if (r_cap == '0) begin
            n_use = ukdp_pkg::t_addr'(1);
        end else if (int'(r_cap) > ukdp_pkg::CAPACITY) begin
            n_use = ukdp_pkg::t_addr'(ukdp_pkg::CAPACITY);
        end else begin
            n_use = ukdp_pkg::t_addr'(r_cap);
        end
    end

    // Row read-out handshake: reissue the same address while the result is stalled
    assign emit_more  = r_e <= ukdp_pkg::t_cnt'(r_use);
    assign emit_load  = i_cmd.emit && r_pend && (!r_res_valid || i_res_ready);
    assign emit_issue = i_cmd.emit && emit_more && (!r_pend || emit_load);

    // Read addresses
    assign base_addr = r_c - ukdp_pkg::t_addr'(r_size);
    assign rd_a_addr = r_c;
    always_comb begin
        if (i_cmd.emit) begin
            rd_b_addr = emit_issue ? ukdp_pkg::t_addr'(r_e) : r_pend_c;
        end else begin
            rd_b_addr = base_addr;
        end
    end

    // Update: forward the write that landed on the read edge, saturate, take max
    always_comb begin
        if (r_fwd_v && (r_fwd_addr == r_upd_b)) begin
            base = r_fwd_data;
        end else begin
            base = r_vb ? rd_b : '0;
        end
        old_v  = r_va ? rd_a : '0;
        sum    = {1'b0, base} + (ukdp_pkg::VALUE_BITS + 1)'(r_value);
        cand   = sum[ukdp_pkg::VALUE_BITS] ? '1 : sum[ukdp_pkg::VALUE_BITS-1:0];
        new_v  = (old_v < cand) ? cand : old_v;
        emit_v = r_vb ? rd_b : '0;
    end

    // Status to the controller
    always_comb begin
        o_stat.skip       = (r_size == '0) ||
                            (r_size > ukdp_pkg::SIZE_W'(r_use));
        o_stat.sweep_last = r_c == r_use;
        o_stat.emit_done  = emit_load && (r_pend_c == r_use);
    end

    ukdp_ram #(
        .WIDTH(ukdp_pkg::VALUE_BITS),
        .DEPTH(ukdp_pkg::DEPTH)
    ) u_ram (
        .i_clk    (i_clk),
        .i_we     (r_upd_v),
        .i_waddr  (r_upd_c),
        .i_wdata  (new_v),
        .i_raddr_a(rd_a_addr),
        .i_raddr_b(rd_b_addr),
        .o_rdata_a(rd_a),
        .o_rdata_b(rd_b)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= ukdp_pkg::CAP_W'(16);
            r_valid     <= '0;
            r_upd_v     <= 1'b0;
            r_fwd_v     <= 1'b0;
            r_pend      <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cap <= i_cfg_capacity_in_use;
            end
            // clear the table on a new set, mark entries as they are written
            if (i_cmd.accept && i_start_new_set) begin
                r_valid <= '0;
            end else if (r_upd_v) begin
                r_valid[r_upd_c] <= 1'b1;
            end
            r_upd_v <= i_cmd.sweep_rd;
            r_fwd_v <= r_upd_v;
            if (emit_issue) begin
                r_pend <= 1'b1;
            end else if (emit_load) begin
                r_pend <= 1'b0;
            end
            if (emit_load) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_size  <= i_item_size;
            r_value <= i_item_value;
            r_use   <= n_use;
            r_c     <= ukdp_pkg::t_addr'(i_item_size);
            r_e     <= ukdp_pkg::t_cnt'(1);
        end else begin
            if (i_cmd.sweep_rd) begin
                r_c <= r_c + ukdp_pkg::t_addr'(1);
            end
            if (emit_issue) begin
                r_e <= r_e + ukdp_pkg::t_cnt'(1);
            end
        end
        r_va       <= r_valid[rd_a_addr];
        r_vb       <= r_valid[rd_b_addr];
        r_upd_c    <= r_c;
        r_upd_b    <= base_addr;
        r_fwd_addr <= r_upd_c;
        r_fwd_data <= new_v;
        if (emit_issue) begin
            r_pend_c <= ukdp_pkg::t_addr'(r_e);
        end
        if (emit_load) begin
            r_res_cap  <= ukdp_pkg::CAP_W'(r_pend_c);
            r_res_val  <= ukdp_pkg::OUT_VAL_W'(emit_v);
            r_res_last <= r_pend_c == r_use;
        end
    end

    assign o_res_valid   = r_res_valid;
    assign o_capacity    = r_res_cap;
    assign o_best_value  = r_res_val;
    assign o_last_of_row = r_res_last;

endmodule

### rtl/unbounded_knapsack_dp_top.sv
// Top level of the unbounded knapsack best-value block.
// Channels:
//   item    : i_item_valid / o_item_ready with i_item_size, i_item_value,
//             i_start_new_set. One transaction brings one goods kind.
//   result  : o_res_valid / i_res_ready with o_capacity, o_best_value,
//             o_last_of_row. One row of results, capacity 1 upward, per item.
//   config  : i_cfg_valid / o_cfg_ready with i_cfg_capacity_in_use; always ready.
// Order of operation:
//   sweep: one table entry a cycle through the two-read, one-write table RAM;
//   then a drain step.
//   The first result follows the last sweep step through drain, read and load;
//   then one result a cycle while the receiver is ready.
//   A new item is taken once the last read of the row is loaded, while that last
//   result may still wait.
// Reset (synchronous, active low) empties the table, sets the capacity in use
// to 16 and drops any pending result.
// When the receiver stalls, the result register holds and the row read-out
// waits; nothing is lost.
// Depends on ukdp_pkg, ukdp_ctrl, ukdp_datapath, ukdp_ram.
module unbounded_knapsack_dp_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ukdp_pkg::CAP_W-1:0]          i_cfg_capacity_in_use,
    input  logic                                i_item_valid,
    output logic                                o_item_ready,
    input  logic [ukdp_pkg::SIZE_W-1:0]         i_item_size,
    input  logic [ukdp_pkg::ITEM_VAL_W-1:0]     i_item_value,
    input  logic                                i_start_new_set,
    output logic                                o_res_valid,
    input  logic                                i_res_ready,
    output logic [ukdp_pkg::CAP_W-1:0]          o_capacity,
    output logic [ukdp_pkg::OUT_VAL_W-1:0]      o_best_value,
    output logic                                o_last_of_row
);

    ukdp_pkg::t_cmd  cmd;
    ukdp_pkg::t_stat stat;

    // Configuration writes are always accepted; the new capacity is used from the next accepted item on
    assign o_cfg_ready = 1'b1;

    ukdp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item_valid(i_item_valid),
        .o_item_ready(o_item_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    ukdp_datapath u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_stat               (stat),
        .i_cfg_valid          (i_cfg_valid),
        .i_cfg_capacity_in_use(i_cfg_capacity_in_use),
        .i_item_size          (i_item_size),
        .i_item_value         (i_item_value),
        .i_start_new_set      (i_start_new_set),
        .o_res_valid          (o_res_valid),
        .i_res_ready          (i_res_ready),
        .o_capacity           (o_capacity),
        .o_best_value         (o_best_value),
        .o_last_of_row        (o_last_of_row)
    );

endmodule

### rtl/ukdp_checker.sv
// Port-level checks for the knapsack block, attached by bind to the top level.
// Depends on ukdp_pkg and unbounded_knapsack_dp_top.
module ukdp_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_item_valid,
    input logic                                o_item_ready,
    input logic                                o_res_valid,
    input logic                                i_res_ready,
    input logic [ukdp_pkg::CAP_W-1:0]          o_capacity,
    input logic [ukdp_pkg::OUT_VAL_W-1:0]      o_best_value,
    input logic                                o_last_of_row
);

    // Reset leaves the block idle with no result pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_item_ready && !o_res_valid))
        else $error("block not idle after reset");

    // An accepted item closes the item channel while it is worked on
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item_valid && o_item_ready) |=> !o_item_ready)
        else $error("item channel still ready after a transaction");

    // Every result reports a real capacity
    a_capacity_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_capacity != '0))
        else $error("result reports capacity zero");

    // A stalled result holds its payload
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !i_res_ready) |=>
            (o_res_valid && $stable(o_capacity) && $stable(o_best_value) &&
             $stable(o_last_of_row)))
        else $error("stalled result changed");

endmodule

bind unbounded_knapsack_dp_top ukdp_checker u_ukdp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_item_valid (i_item_valid),
    .o_item_ready (o_item_ready),
    .o_res_valid  (o_res_valid),
    .i_res_ready  (i_res_ready),
    .o_capacity   (o_capacity),
    .o_best_value (o_best_value),
    .o_last_of_row(o_last_of_row)
);
